>>> rtl/core/add_days_to_date_defines.svh
// ----------------------------------------------------------------------------
// add_days_to_date assertion macros
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ADD_DAYS_TO_DATE_DEFINES_SVH
`define ADD_DAYS_TO_DATE_DEFINES_SVH
`ifndef SYNTHESIS
// consequent must hold in the same cycle as the antecedent
`define ADTD_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("adtd check failed");
// consequent must hold in the cycle after the antecedent
`define ADTD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("adtd check failed");
`else
`define ADTD_ASSERT_SAME(label, clk, rst, ante, cons)
`define ADTD_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

>>> rtl/core/adtd_pkg.sv
// ----------------------------------------------------------------------------
// adtd_pkg
// Field widths, calendar constants and month length lookup for the date adder.
// ----------------------------------------------------------------------------
package adtd_pkg;

  localparam int YEAR_W = 14;
  localparam int MON_W  = 4;
  localparam int DAY_W  = 5;
  localparam int OFF_W  = 17;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 24;
  localparam int OUT_USER_W = 2;

  // Gregorian cycle and month count
  localparam int YEAR_CYCLE = 400;
  localparam int MONTHS     = 12;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_CHECK,
    ST_FWD,
    ST_BACK,
    ST_FIN
  } adtd_state_t;

  // Leap test on the year taken modulo 400
  function automatic logic is_leap(input logic [8:0] ymod);
    is_leap = (ymod[1:0] == 2'b00) && (ymod != 9'd100) && (ymod != 9'd200)
              && (ymod != 9'd300);
  endfunction

  // Days in a month; zero for a month code outside 1..12
  function automatic logic [DAY_W-1:0] month_days(input logic leap,
                                                  input logic [MON_W-1:0] mon);
    unique case (mon) inside
      4'd2:                                   month_days = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:                month_days = 5'd30;
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: month_days = 5'd31;
      default:                                month_days = 5'd0;
    endcase
  endfunction

endpackage

>>> rtl/core/add_days_to_date.sv
// ----------------------------------------------------------------------------
// add_days_to_date
// Adds a signed day offset to a Gregorian date, one month per cycle.
// ----------------------------------------------------------------------------
//  channel | dir | tdata (low bit up)                         | tuser (low bit up)
//  s_axis  | in  | year_in 14, month_in 4, day_in 5,           | -
//          |     | day_offset 17 (signed)                     |
//  m_axis  | out | year_out 14, month_out 4, day_out 5, pad 1 | input_invalid,
//          |     |                                            | out_of_range
//
//  A transaction runs through the idle, year-mod-400 reduction, check, month walk
//  and final states, the walk dropping out for an invalid date. The month carry
//  loop through the single day adder is the longest part for large offsets.
//  rst is synchronous and clears the sequencer and the output valid.
//  A finished result waits in the output register while the next input is
//  taken; the sequencer holds in its final state only if that register is full.
`include "add_days_to_date_defines.svh"

module add_days_to_date #(
  parameter int OFFSET_LIMIT = 65535,
  parameter int YEAR_MAX     = 9999
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // year_in[13:0], month_in[17:14], day_in[22:18], day_offset[39:23]
  input  logic [adtd_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // year_out[13:0], month_out[17:14], day_out[22:18], zero[23]
  output logic [adtd_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // input_invalid[0], out_of_range[1]
  output logic [adtd_pkg::OUT_USER_W-1:0] m_axis_tuser
);
  import adtd_pkg::*;

  localparam logic [20:0]        LIMIT    = 21'(OFFSET_LIMIT);
  localparam logic signed [16:0] YEAR_TOP = 17'(YEAR_MAX);
  localparam logic [13:0]        CYC14    = 14'(YEAR_CYCLE);
  localparam logic [8:0]         CYC_LAST = 9'(YEAR_CYCLE - 1);

  adtd_state_t state, state_next;

  // input copy
  logic [YEAR_W-1:0] y0, y0_next;
  logic [MON_W-1:0]  m0, m0_next;
  logic [DAY_W-1:0]  d0, d0_next;
  logic              neg, neg_next;

  // working registers
  logic [OFF_W-1:0]        left, left_next;
  logic signed [17:0]      acc, acc_next;
  logic [MON_W-1:0]        mon, mon_next;
  logic signed [16:0]      year, year_next;
  logic [YEAR_W-1:0]       year_mod, year_mod_next;
  logic                    bad_in, bad_in_next;

  // output register
  logic              out_valid, out_valid_next;
  logic [YEAR_W-1:0] year_q, year_q_next;
  logic [MON_W-1:0]  mon_q, mon_q_next;
  logic [DAY_W-1:0]  day_q, day_q_next;
  logic              inv_q, inv_q_next;
  logic              oor_q, oor_q_next;

  // unpacked input fields
  logic [YEAR_W-1:0] in_year;
  logic [MON_W-1:0]  in_mon;
  logic [DAY_W-1:0]  in_day;
  logic [OFF_W-1:0]  in_off;
  logic [OFF_W-1:0]  in_mag;
  logic [OFF_W-1:0]  sat_mag;

  // month step helpers
  logic [8:0]       ymod9;
  logic [8:0]       ymod_inc, ymod_dec;
  logic [MON_W-1:0] mon_dec;
  logic             wrap_dec;
  logic [DAY_W-1:0] dim_cur, dim_prev, dim_start;
  logic [5:0]       gap;
  logic             in_acc, fin_load, out_bad;

  assign in_year = s_axis_tdata[13:0];
  assign in_mon  = s_axis_tdata[17:14];
  assign in_day  = s_axis_tdata[22:18];
  assign in_off  = s_axis_tdata[39:23];

  // offset magnitude, clipped to the limit
  assign in_mag  = in_off[OFF_W-1] ? (~in_off + 17'd1) : in_off;
  assign sat_mag = ({4'd0, in_mag} > LIMIT) ? LIMIT[OFF_W-1:0] : in_mag;

  assign ymod9     = year_mod[8:0];
  assign ymod_inc  = (ymod9 == CYC_LAST) ? 9'd0 : ymod9 + 9'd1;
  assign ymod_dec  = (ymod9 == 9'd0) ? CYC_LAST : ymod9 - 9'd1;
  assign wrap_dec  = (mon == 4'd1);
  assign mon_dec   = wrap_dec ? 4'(MONTHS) : mon - 4'd1;
  assign dim_cur   = month_days(is_leap(ymod9), mon);
  assign dim_prev  = month_days(is_leap(wrap_dec ? ymod_dec : ymod9), mon_dec);
  assign dim_start = month_days(is_leap(ymod9), m0);
  assign gap       = 6'(dim_cur) - 6'(acc[4:0]) + 6'd1;

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign fin_load = (state == ST_FIN) && (!out_valid || m_axis_tready);
  assign out_bad  = !bad_in && ((year < 17'sd1) || (year > YEAR_TOP));

  // sequencer and shared datapath
  always_comb begin
    state_next     = state;
    y0_next        = y0;
    m0_next        = m0;
    d0_next        = d0;
    neg_next       = neg;
    left_next      = left;
    acc_next       = acc;
    mon_next       = mon;
    year_next      = year;
    year_mod_next  = year_mod;
    bad_in_next    = bad_in;
    year_q_next    = year_q;
    mon_q_next     = mon_q;
    day_q_next     = day_q;
    inv_q_next     = inv_q;
    oor_q_next     = oor_q;
    out_valid_next = out_valid;
    s_axis_tready  = 1'b0;

    // drop the result once taken
    if (m_axis_tready) begin
      out_valid_next = 1'b0;
    end

    unique case (state)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (in_acc) begin
          y0_next       = in_year;
          m0_next       = in_mon;
          d0_next       = in_day;
          neg_next      = in_off[OFF_W-1];
          left_next     = sat_mag;
          year_mod_next = in_year;
          state_next    = ST_MOD;
        end
      end
      // reduce the year modulo 400 by repeated subtraction
      ST_MOD: begin
        if (year_mod >= CYC14) begin
          year_mod_next = year_mod - CYC14;
        end else begin
          state_next = ST_CHECK;
        end
      end
      // validate the start date and set up the walk
      ST_CHECK: begin
        bad_in_next = (y0 == '0) || (m0 == '0) || (m0 > 4'(MONTHS)) || (d0 == '0)
                      || (d0 > dim_start);
        year_next   = signed'({3'b000, y0});
        mon_next    = m0;
        if (bad_in_next) begin
          state_next = ST_FIN;
        end else if (neg) begin
          acc_next   = signed'(18'(d0)) - signed'(18'(left));
          state_next = ST_BACK;
        end else begin
          acc_next   = signed'(18'(d0));
          state_next = ST_FWD;
        end
      end
      // advance one month, or finish inside the current one
      ST_FWD: begin
        if (left < 17'(gap)) begin
          acc_next   = acc + signed'(18'(left));
          state_next = ST_FIN;
        end else begin
          left_next = left - 17'(gap);
          acc_next  = 18'sd1;
          if (mon == 4'(MONTHS)) begin
            mon_next      = 4'd1;
            year_next     = year + 17'sd1;
            year_mod_next = 14'(ymod_inc);
          end else begin
            mon_next = mon + 4'd1;
          end
        end
      end
      // borrow one month while the day is not positive
      ST_BACK: begin
        if (acc > 18'sd0) begin
          state_next = ST_FIN;
        end else begin
          mon_next = mon_dec;
          acc_next = acc + signed'(18'(dim_prev));
          if (wrap_dec) begin
            year_next     = year - 17'sd1;
            year_mod_next = 14'(ymod_dec);
          end
        end
      end
      // range check and hand the result to the output register
      ST_FIN: begin
        if (fin_load) begin
          out_valid_next = 1'b1;
          inv_q_next     = bad_in;
          oor_q_next     = out_bad;
          if (bad_in || out_bad) begin
            year_q_next = y0;
            mon_q_next  = m0;
            day_q_next  = d0;
          end else begin
            year_q_next = year[13:0];
            mon_q_next  = mon;
            day_q_next  = acc[4:0];
          end
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    y0       <= y0_next;
    m0       <= m0_next;
    d0       <= d0_next;
    neg      <= neg_next;
    left     <= left_next;
    acc      <= acc_next;
    mon      <= mon_next;
    year     <= year_next;
    year_mod <= year_mod_next;
    bad_in   <= bad_in_next;
    year_q   <= year_q_next;
    mon_q    <= mon_q_next;
    day_q    <= day_q_next;
    inv_q    <= inv_q_next;
    oor_q    <= oor_q_next;
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {1'b0, day_q, mon_q, year_q};
  assign m_axis_tuser  = {oor_q, inv_q};

  `ADTD_ASSERT_SAME(a_flags_exclusive, clk, rst, m_axis_tvalid, !(m_axis_tuser[0] && m_axis_tuser[1]))
  `ADTD_ASSERT_NEXT(a_accept_starts_mod, clk, rst, s_axis_tvalid && s_axis_tready, state == ST_MOD)
  `ADTD_ASSERT_SAME(a_walk_month_ok, clk, rst, (state == ST_FWD) || (state == ST_BACK), (mon >= 4'd1) && (mon <= 4'(MONTHS)))
  `ADTD_ASSERT_SAME(a_walk_mod_ok, clk, rst, (state == ST_FWD) || (state == ST_BACK), year_mod < CYC14)

endmodule
